[hdl/hmac_sha256_engine_defines.svh]
// Assertion macros for the HMAC-SHA256 engine RTL.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef HMAC_SHA256_ENGINE_DEFINES_SVH
`define HMAC_SHA256_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define HSE_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define HSE_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/hse_pkg.sv]
// Shared types and constants for the HMAC-SHA256 engine.
// No dependencies.
package hse_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QADDR_W     = $clog2(QUEUE_DEPTH);

    // SHA-256 initial hash value, H0 in the top bits
    localparam logic [255:0] SHA_IV = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Request codes
    localparam logic FUNC_KEY = 1'b0;
    localparam logic FUNC_MSG = 1'b1;

    // One classified request
    typedef struct packed {
        logic        func;
        logic [63:0] chunk;
        logic [3:0]  count;
        logic        last;
    } hse_item_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_KEY,
        PH_MSG
    } hse_phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INSERT,
        ST_FIN,
        ST_ZERO,
        ST_LEN,
        ST_CMP_GO,
        ST_CMP_WAIT,
        ST_DONEH,
        ST_KEYEND,
        ST_OUTER2,
        ST_OUT
    } hse_state_t;

    // SHA-256 round constants
    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage

[hdl/hse_front.sv]
// Front end: accepts requests, clamps the byte count and queues them.
// Depends on hse_pkg.
module hse_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              in_func,
    input  logic [63:0]       in_chunk,
    input  logic [3:0]        in_count,
    input  logic              in_last,
    output hse_pkg::hse_item_t item,
    output logic              item_valid,
    input  logic              item_pop
);
    import hse_pkg::*;

    hse_item_t          q_mem [QUEUE_DEPTH];
    logic [QADDR_W:0]   wr_ptr_reg, wr_ptr_next;
    logic [QADDR_W:0]   rd_ptr_reg, rd_ptr_next;
    logic               empty, full, push;
    hse_item_t          wr_item;

    // Pointer compare with wrap bit
    assign empty = (wr_ptr_reg == rd_ptr_reg);
    assign full  = (wr_ptr_reg[QADDR_W] != rd_ptr_reg[QADDR_W]) &&
                   (wr_ptr_reg[QADDR_W-1:0] == rd_ptr_reg[QADDR_W-1:0]);
    assign in_ready   = !full;
    assign push       = in_valid && !full;
    assign item_valid = !empty;
    assign item       = q_mem[rd_ptr_reg[QADDR_W-1:0]];

    // Classify: counts above eight mean eight
    always_comb
    begin
        wr_item.func  = in_func;
        wr_item.chunk = in_chunk;
        wr_item.count = (in_count > 4'd8) ? 4'd8 : in_count;
        wr_item.last  = in_last;
    end

    assign wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
    assign rd_ptr_next = (item_pop && !empty) ? rd_ptr_reg + 1'b1 : rd_ptr_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg[QADDR_W-1:0]] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

endmodule

[hdl/hse_core.sv]
// SHA-256 compression unit, one round per cycle with a rolling schedule.
// Depends on hse_pkg for the round constants.
module hse_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [511:0] block,
    input  logic [255:0] cv_in,
    output logic         done,
    output logic [255:0] digest
);
    import hse_pkg::*;

    logic [31:0]  v_reg [8];
    logic [31:0]  v_next [8];
    logic [31:0]  w_reg [16];
    logic [31:0]  w_next [16];
    logic [255:0] hv_reg;
    logic [5:0]   cnt_reg, cnt_next;
    logic         busy_reg, busy_next;
    logic         fin_reg, fin_next;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // One round plus the next schedule word
    always_comb
    begin
        logic [31:0] t1, t2, s0, s1, wn;
        s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        wn = s1 + w_reg[9] + s0 + w_reg[0];
        t1 = v_reg[7] + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + round_k(cnt_reg) + w_reg[0];
        t2 = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22))
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        v_next = v_reg;
        w_next = w_reg;
        if (start)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_next[i] = cv_in[32*(7-i) +: 32];
            end
            for (int i = 0; i < 16; i++)
            begin
                w_next[i] = block[32*(15-i) +: 32];
            end
        end
        else if (busy_reg)
        begin
            v_next[7] = v_reg[6];
            v_next[6] = v_reg[5];
            v_next[5] = v_reg[4];
            v_next[4] = v_reg[3] + t1;
            v_next[3] = v_reg[2];
            v_next[2] = v_reg[1];
            v_next[1] = v_reg[0];
            v_next[0] = t1 + t2;
            for (int i = 0; i < 15; i++)
            begin
                w_next[i] = w_reg[i+1];
            end
            w_next[15] = wn;
        end
    end

    // Round counter and control
    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        fin_next  = 1'b0;
        if (start)
        begin
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == 6'd63)
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end
    end

    // Feed-forward add
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            digest[32*(7-i) +: 32] = hv_reg[32*(7-i) +: 32] + v_reg[i];
        end
    end
    assign done = fin_reg;

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        w_reg <= w_next;
        cnt_reg <= cnt_next;
        if (start)
        begin
            hv_reg <= cv_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
        end
    end

endmodule

[hdl/hse_back.sv]
// Back end: packs bytes into blocks, pads, runs the inner and outer hashes
// through hse_core and returns the digest. Uses hse_pkg, hse_core, macros.
`include "hmac_sha256_engine_defines.svh"
module hse_back (
    input  logic               clk,
    input  logic               rst_n,
    input  hse_pkg::hse_item_t item,
    input  logic               item_valid,
    output logic               item_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [63:0]        out_word,
    output logic               out_last
);
    import hse_pkg::*;

    hse_state_t   state_reg, state_next;
    hse_state_t   ret_reg, ret_next;
    hse_phase_t   phase_reg, phase_next;
    logic [511:0] key_reg, key_next;
    logic [511:0] buf_reg, buf_next;
    logic [255:0] cv_reg, cv_next;
    logic [255:0] inner_reg, inner_next;
    logic [63:0]  bs_reg, bs_next;
    logic [6:0]   fill_reg, fill_next;
    logic         khash_reg, khash_next;
    logic [63:0]  dat_reg, dat_next;
    logic [3:0]   rem_reg, rem_next;
    logic         last_reg, last_next;
    logic [1:0]   idx_reg, idx_next;
    logic         core_start, core_done;
    logic [255:0] core_digest;
    logic [6:0]   space, k7;

    hse_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (core_start),
        .block  (buf_reg),
        .cv_in  (cv_reg),
        .done   (core_done),
        .digest (core_digest)
    );

    // Bytes that fit before the block fills
    assign space = 7'd64 - fill_reg;
    assign k7    = (space < {3'b0, rem_reg}) ? space : {3'b0, rem_reg};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ST_INSERT;
                end
            end
            ST_INSERT:
            begin
                if (rem_reg != 4'd0)
                begin
                    state_next = (fill_reg == 7'd64) ? ST_CMP_GO : ST_INSERT;
                end
                else if (!last_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (phase_reg == PH_KEY && !khash_reg)
                begin
                    state_next = ST_KEYEND;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                state_next = (fill_reg >= 7'd56) ? ST_CMP_GO : ST_LEN;
            end
            ST_ZERO:     state_next = ST_LEN;
            ST_LEN:      state_next = ST_CMP_GO;
            ST_CMP_GO:   state_next = ST_CMP_WAIT;
            ST_CMP_WAIT:
            begin
                if (core_done)
                begin
                    state_next = ret_reg;
                end
            end
            ST_DONEH:
            begin
                state_next = (phase_reg == PH_KEY) ? ST_IDLE : ST_CMP_GO;
            end
            ST_KEYEND:   state_next = ST_IDLE;
            ST_OUTER2:   state_next = ST_CMP_GO;
            ST_OUT:
            begin
                if (out_ready && idx_reg == 2'd3)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        logic [6:0] off;
        off        = '0;
        ret_next   = ret_reg;
        phase_next = phase_reg;
        key_next   = key_reg;
        buf_next   = buf_reg;
        cv_next    = cv_reg;
        inner_next = inner_reg;
        bs_next    = bs_reg;
        fill_next  = fill_reg;
        khash_next = khash_reg;
        dat_next   = dat_reg;
        rem_next   = rem_reg;
        last_next  = last_reg;
        idx_next   = idx_reg;
        item_pop   = 1'b0;
        core_start = (state_reg == ST_CMP_GO);
        out_valid  = (state_reg == ST_OUT);
        out_last   = (idx_reg == 2'd3);
        out_word   = cv_reg[{2'd3 - idx_reg, 6'b0} +: 64];
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    item_pop  = 1'b1;
                    dat_next  = item.chunk;
                    rem_next  = item.count;
                    last_next = item.last;
                    idx_next  = '0;
                    // A request of the other kind opens a new run
                    if (item.func == FUNC_KEY && phase_reg != PH_KEY)
                    begin
                        phase_next = PH_KEY;
                        bs_next    = '0;
                        fill_next  = '0;
                        khash_next = 1'b0;
                    end
                    else if (item.func == FUNC_MSG && phase_reg != PH_MSG)
                    begin
                        phase_next = PH_MSG;
                        khash_next = 1'b0;
                        cv_next    = SHA_IV;
                        buf_next   = key_reg ^ {64{8'h36}};
                        bs_next    = 64'd64;
                        fill_next  = 7'd64;
                    end
                end
            end
            ST_INSERT:
            begin
                if (rem_reg != 4'd0)
                begin
                    if (fill_reg == 7'd64)
                    begin
                        // Full block waits for more bytes before compressing
                        fill_next = '0;
                        ret_next  = ST_INSERT;
                        if (phase_reg == PH_KEY && !khash_reg)
                        begin
                            cv_next    = SHA_IV;
                            khash_next = 1'b1;
                        end
                    end
                    else
                    begin
                        for (int p = 0; p < 64; p++)
                        begin
                            off = 7'(p) - fill_reg;
                            if (7'(p) >= fill_reg && off < k7)
                            begin
                                buf_next[8*(63-p) +: 8] = dat_reg[8*(7-int'(off[2:0])) +: 8];
                            end
                        end
                        dat_next  = dat_reg << {k7[3:0], 3'b0};
                        rem_next  = rem_reg - k7[3:0];
                        fill_next = fill_reg + k7;
                        bs_next   = bs_reg + 64'(k7);
                    end
                end
            end
            ST_FIN:
            begin
                if (fill_reg == 7'd64)
                begin
                    fill_next = '0;
                    ret_next  = ST_FIN;
                end
                else
                begin
                    // Marker byte then zeros
                    for (int p = 0; p < 64; p++)
                    begin
                        if (7'(p) == fill_reg)
                        begin
                            buf_next[8*(63-p) +: 8] = 8'h80;
                        end
                        else if (7'(p) > fill_reg)
                        begin
                            buf_next[8*(63-p) +: 8] = 8'h00;
                        end
                    end
                    ret_next = ST_ZERO;
                end
            end
            ST_ZERO:
            begin
                buf_next = '0;
            end
            ST_LEN:
            begin
                buf_next[63:0] = bs_reg << 3;
                ret_next       = ST_DONEH;
            end
            ST_CMP_WAIT:
            begin
                if (core_done)
                begin
                    cv_next = core_digest;
                end
            end
            ST_DONEH:
            begin
                if (phase_reg == PH_KEY)
                begin
                    key_next   = {cv_reg, 256'b0};
                    phase_next = PH_IDLE;
                    khash_next = 1'b0;
                    bs_next    = '0;
                    fill_next  = '0;
                end
                else
                begin
                    inner_next = cv_reg;
                    cv_next    = SHA_IV;
                    buf_next   = key_reg ^ {64{8'h5c}};
                    ret_next   = ST_OUTER2;
                end
            end
            ST_KEYEND:
            begin
                // Short key: keep the filled bytes, zero the rest
                for (int p = 0; p < 64; p++)
                begin
                    key_next[8*(63-p) +: 8] = (7'(p) < fill_reg) ? buf_reg[8*(63-p) +: 8]
                                                                 : 8'h00;
                end
                phase_next = PH_IDLE;
                khash_next = 1'b0;
                bs_next    = '0;
                fill_next  = '0;
            end
            ST_OUTER2:
            begin
                buf_next = {inner_reg, 32'h80000000, 160'b0, 64'd768};
                ret_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == 2'd3)
                    begin
                        phase_next = PH_IDLE;
                        bs_next    = '0;
                        fill_next  = '0;
                    end
                end
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        buf_reg   <= buf_next;
        inner_reg <= inner_next;
        dat_reg   <= dat_next;
        rem_reg   <= rem_next;
        last_reg  <= last_next;
    end

    // Control and kept state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            phase_reg <= PH_IDLE;
            key_reg   <= '0;
            cv_reg    <= SHA_IV;
            bs_reg    <= '0;
            fill_reg  <= '0;
            khash_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            phase_reg <= phase_next;
            key_reg   <= key_next;
            cv_reg    <= cv_next;
            bs_reg    <= bs_next;
            fill_reg  <= fill_next;
            khash_reg <= khash_next;
            idx_reg   <= idx_next;
        end
    end

    `HSE_ASSERT_IMP(a_fill_range, 1'b1, fill_reg <= 7'd64, "block fill above 64")
    `HSE_ASSERT_IMP(a_out_in_msg, out_valid, phase_reg == PH_MSG, "digest outside message")
    `HSE_ASSERT_IMP(a_done_wait, core_done, state_reg == ST_CMP_WAIT, "unexpected core done")
    `HSE_ASSERT_NXT(a_out_end, out_valid && out_ready && out_last,
                    state_reg == ST_IDLE && phase_reg == PH_IDLE, "run not closed")

endmodule

[hdl/hmac_sha256_engine.sv]
// HMAC-SHA256 engine top level: input queue, sequencer and compression unit.
// Depends on hse_pkg, hse_front, hse_back.
//
// Input stream: tuser selects key (0) or message (1) bytes; tdata carries
// up to eight big-endian bytes and a byte count; tlast closes a key or message.
// A longer key is hashed first; the kept key stays until the next key ends.
// Output stream: four 64-bit HMAC words, most significant first, tlast on
// the fourth. A key run returns nothing.
// A queued request is popped, then merged into the block buffer; each
// 64-byte block is loaded into the compression unit, run one round per cycle
// and fed forward. After the final message request, padding and the outer
// hash take three to four more compressions before the first word.
// A four-entry request queue accepts until full while the back end compresses
// or waits on a stalled receiver; the back end holds the digest until taken.
// Reset empties the queue, restores the empty key and closes any open run.
module hmac_sha256_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // chunk[63:0], byte_count[67:64], zero pad
    input  logic [0:0]  s_axis_tuser,  // func
    input  logic        s_axis_tlast,  // final_chunk
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // digest_word
    output logic        m_axis_tlast   // final_word
);
    import hse_pkg::*;

    hse_item_t item;
    logic      item_valid, item_pop;

    hse_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_func    (s_axis_tuser[0]),
        .in_chunk   (s_axis_tdata[63:0]),
        .in_count   (s_axis_tdata[67:64]),
        .in_last    (s_axis_tlast),
        .item       (item),
        .item_valid (item_valid),
        .item_pop   (item_pop)
    );

    hse_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_valid (item_valid),
        .item_pop   (item_pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_word   (m_axis_tdata),
        .out_last   (m_axis_tlast)
    );

endmodule
